FILE: src/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg: shared types and codes for the sphere collision resolver
// Request and status codes, slot entry layout, sequencer states.
// ----------------------------------------------------------------------------
package scr_pkg;

    localparam int SLOTS_DEF = 64;

    typedef enum logic [1:0] {
        REQ_ADD     = 2'd0,
        REQ_REMOVE  = 2'd1,
        REQ_RESOLVE = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        logic        [30:0] radius;
        logic signed [31:0] cz;
        logic signed [31:0] cy;
        logic signed [31:0] cx;
        logic        [15:0] ident;
    } t_slot_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_WALK,
        S_EVAL,
        S_MUL,
        S_CMP,
        S_SQRT,
        S_DMUL,
        S_DINIT,
        S_DIV,
        S_DAPPLY,
        S_NEXT,
        S_DONE
    } t_state;

    // clamp a 34-bit signed sum into the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] res;
        if (v > 34'sh0_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

FILE: src/scr_slot_ram.sv
// ----------------------------------------------------------------------------
// scr_slot_ram: slot table storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module scr_slot_ram #(
    parameter int DEPTH = scr_pkg::SLOTS_DEF,
    parameter int AW    = 6
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  scr_pkg::t_slot_entry i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output scr_pkg::t_slot_entry o_rdata
);
    import scr_pkg::*;

    t_slot_entry mem [DEPTH];
    t_slot_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/sphere_collision_resolver.sv
// ----------------------------------------------------------------------------
// sphere_collision_resolver: static sphere table with push-out resolve
// Add, remove and resolve requests against a table of static spheres.
// ----------------------------------------------------------------------------
// One request is handled at a time. Add scans the valid bits one slot per
// cycle. Remove and resolve walk the slot RAM, one read per valid slot; for
// resolve, a slot that passes the early rejects gets a squared-distance test
// through the shared 32x32 multiplier. Each collision with distinct centres
// runs a 32-step integer square root and, per axis, a multiply, a load, a
// 32-step division and an apply step, one bit per cycle in the root and the
// division. The result waits in an output register, so the next request is
// taken while it is still unread.
// ----------------------------------------------------------------------------
module sphere_collision_resolver #(
    parameter int SLOTS = scr_pkg::SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // sphere_id[15:0], pos_x[47:16], pos_y[79:48], pos_z[111:80],
    // radius[142:112], zero pad[143]
    input  logic [143:0] i_s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // new_x[31:0], new_y[63:32], new_z[95:64], hits[102:96], slot[108:103],
    // zero pad[111:109]
    output logic [111:0] o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]   o_m_axis_tuser
);
    import scr_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    t_state r_state, n_state;

    logic [SLOTS-1:0]   r_valid;
    logic [1:0]         r_req;
    logic [15:0]        r_id;
    logic signed [31:0] r_px, r_py, r_pz;
    logic [30:0]        r_rad;
    logic [IW-1:0]      r_idx;
    logic [6:0]         r_hits;
    logic [5:0]         r_slot;
    logic [1:0]         r_status;

    logic [31:0]        r_mag [3];
    logic [2:0]         r_neg;
    logic [31:0]        r_s;
    logic [2:0]         r_step;
    logic [63:0]        r_prod;
    logic [65:0]        r_sum;
    logic [63:0]        r_s2;
    logic [63:0]        r_sv;
    logic [33:0]        r_srem;
    logic [31:0]        r_root;
    logic [4:0]         r_bit;
    logic [31:0]        r_rem;
    logic [31:0]        r_dq;

    logic               r_out_valid;
    logic [111:0]       r_out_data;
    logic [1:0]         r_out_user;

    t_slot_entry        rd;
    t_slot_entry        wr;
    logic               mem_we, mem_re, in_xfer, out_load, cur_valid, is_last;

    assign in_xfer   = i_s_axis_tvalid && o_s_axis_tready;
    assign cur_valid = r_valid[r_idx];
    assign is_last   = (r_idx == LAST);

    assign wr.ident  = r_id;
    assign wr.cx     = r_px;
    assign wr.cy     = r_py;
    assign wr.cz     = r_pz;
    assign wr.radius = r_rad;

    scr_slot_ram #(.DEPTH(SLOTS), .AW(IW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(r_idx),
        .i_wdata(wr),
        .i_re   (mem_re),
        .i_raddr(r_idx),
        .o_rdata(rd)
    );

    // slot evaluation: distance components and early rejects
    logic [31:0]        e_s;
    logic signed [32:0] e_d [3];
    logic [32:0]        e_m [3];
    logic               e_reject;

    always_comb begin
        e_s    = {1'b0, r_rad} + {1'b0, rd.radius};
        e_d[0] = {r_px[31], r_px} - {rd.cx[31], rd.cx};
        e_d[1] = {r_py[31], r_py} - {rd.cy[31], rd.cy};
        e_d[2] = {r_pz[31], r_pz} - {rd.cz[31], rd.cz};
        e_reject = (e_s == 32'd0);
        for (int k = 0; k < 3; k++) begin
            e_m[k] = e_d[k][32] ? 33'(-e_d[k]) : 33'(e_d[k]);
            if (e_m[k] >= {1'b0, e_s}) begin
                e_reject = 1'b1;
            end
        end
    end

    // shared multiplier operands
    logic [31:0] mul_a, mul_b;
    always_comb begin
        mul_a = r_s;
        mul_b = r_s;
        if (r_state == S_MUL) begin
            unique case (r_step)
                3'd0:    begin mul_a = r_mag[0]; mul_b = r_mag[0]; end
                3'd1:    begin mul_a = r_mag[1]; mul_b = r_mag[1]; end
                3'd2:    begin mul_a = r_mag[2]; mul_b = r_mag[2]; end
                default: begin mul_a = r_s;      mul_b = r_s;      end
            endcase
        end else begin
            unique case (r_step[1:0])
                2'd0:    mul_a = r_mag[0];
                2'd1:    mul_a = r_mag[1];
                default: mul_a = r_mag[2];
            endcase
        end
    end

    // square root and division steps
    logic [33:0] sq_rem2, sq_trial;
    logic [32:0] dv_t;
    always_comb begin
        sq_rem2  = {r_srem[31:0], r_sv[63:62]};
        sq_trial = {r_root, 2'b01};
        dv_t     = {r_rem, r_dq[31]};
    end

    // apply one pushed-out component
    logic signed [31:0] ap_c;
    logic signed [33:0] ap_off;
    logic signed [31:0] ap_new;
    logic               ap_neg;
    always_comb begin
        unique case (r_step[1:0])
            2'd0:    begin ap_c = rd.cx; ap_neg = r_neg[0]; end
            2'd1:    begin ap_c = rd.cy; ap_neg = r_neg[1]; end
            default: begin ap_c = rd.cz; ap_neg = r_neg[2]; end
        endcase
        ap_off = ap_neg ? -$signed({2'b00, r_dq}) : $signed({2'b00, r_dq});
        ap_new = sat32($signed({{2{ap_c[31]}}, ap_c}) + ap_off);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (t_req'(i_s_axis_tuser))
                        REQ_ADD:                n_state = S_ADD;
                        REQ_REMOVE, REQ_RESOLVE: n_state = S_WALK;
                        default:                n_state = S_DONE;
                    endcase
                end
            end
            S_ADD: begin
                if (!cur_valid || is_last) n_state = S_DONE;
            end
            S_WALK:  n_state = cur_valid ? S_EVAL : S_NEXT;
            S_EVAL: begin
                if (t_req'(r_req) == REQ_REMOVE) begin
                    n_state = (rd.ident == r_id) ? S_DONE : S_NEXT;
                end else begin
                    n_state = e_reject ? S_NEXT : S_MUL;
                end
            end
            S_MUL:   if (r_step == 3'd4) n_state = S_CMP;
            S_CMP: begin
                if ({2'b00, r_s2} <= r_sum || r_sum == 66'd0) n_state = S_NEXT;
                else n_state = S_SQRT;
            end
            S_SQRT:  if (r_bit == 5'd0) n_state = S_DMUL;
            S_DMUL:  n_state = S_DINIT;
            S_DINIT: n_state = S_DIV;
            S_DIV:   if (r_bit == 5'd0) n_state = S_DAPPLY;
            S_DAPPLY: n_state = (r_step[1:0] == 2'd2) ? S_NEXT : S_DMUL;
            S_NEXT:  n_state = is_last ? S_DONE : S_WALK;
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        mem_we          = (r_state == S_ADD) && !cur_valid;
        mem_re          = (r_state == S_WALK) && cur_valid;
        out_load        = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mem_we) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (r_state == S_EVAL && t_req'(r_req) == REQ_REMOVE && rd.ident == r_id) begin
                r_valid[r_idx] <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_req    <= i_s_axis_tuser;
                r_id     <= i_s_axis_tdata[15:0];
                r_px     <= i_s_axis_tdata[47:16];
                r_py     <= i_s_axis_tdata[79:48];
                r_pz     <= i_s_axis_tdata[111:80];
                r_rad    <= i_s_axis_tdata[142:112];
                r_idx    <= '0;
                r_hits   <= '0;
                r_slot   <= '0;
                r_status <= ST_OK;
            end
            S_ADD: begin
                if (!cur_valid) begin
                    r_slot <= 6'(r_idx);
                end else if (is_last) begin
                    r_status <= ST_FULL;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_WALK: ;
            S_EVAL: begin
                if (t_req'(r_req) == REQ_REMOVE && rd.ident == r_id) begin
                    r_slot <= 6'(r_idx);
                end
                for (int k = 0; k < 3; k++) begin
                    r_mag[k] <= e_m[k][31:0];
                    r_neg[k] <= e_d[k][32];
                end
                r_s    <= e_s;
                r_step <= '0;
                r_sum  <= '0;
            end
            S_MUL: begin
                r_prod <= mul_a * mul_b;
                if (r_step != 3'd0 && r_step != 3'd4) begin
                    r_sum <= r_sum + {2'b00, r_prod};
                end
                if (r_step == 3'd4) begin
                    r_s2 <= r_prod;
                end
                r_step <= r_step + 1'b1;
            end
            S_CMP: begin
                if ({2'b00, r_s2} > r_sum && r_sum == 66'd0) begin
                    r_px <= sat32($signed({{2{rd.cx[31]}}, rd.cx}) +
                                  $signed({2'b00, r_s}));
                    r_py <= rd.cy;
                    r_pz <= rd.cz;
                    if (r_hits != 7'd127) r_hits <= r_hits + 1'b1;
                end
                r_sv   <= r_sum[63:0];
                r_srem <= '0;
                r_root <= '0;
                r_bit  <= 5'd31;
                r_step <= '0;
            end
            S_SQRT: begin
                if (sq_rem2 >= sq_trial) begin
                    r_srem <= sq_rem2 - sq_trial;
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_srem <= sq_rem2;
                    r_root <= {r_root[30:0], 1'b0};
                end
                r_sv  <= {r_sv[61:0], 2'b00};
                r_bit <= r_bit - 1'b1;
            end
            S_DMUL: begin
                r_prod <= mul_a * mul_b;
            end
            S_DINIT: begin
                // quotient never exceeds the radius sum, so the high word is
                // already below the divisor
                r_rem <= r_prod[63:32];
                r_dq  <= r_prod[31:0];
                r_bit <= 5'd31;
            end
            S_DIV: begin
                if (dv_t >= {1'b0, r_root}) begin
                    r_rem <= 32'(dv_t - {1'b0, r_root});
                    r_dq  <= {r_dq[30:0], 1'b1};
                end else begin
                    r_rem <= dv_t[31:0];
                    r_dq  <= {r_dq[30:0], 1'b0};
                end
                r_bit <= r_bit - 1'b1;
            end
            S_DAPPLY: begin
                unique case (r_step[1:0])
                    2'd0:    r_px <= ap_new;
                    2'd1:    r_py <= ap_new;
                    default: r_pz <= ap_new;
                endcase
                if (r_step[1:0] == 2'd2) begin
                    if (r_hits != 7'd127) r_hits <= r_hits + 1'b1;
                end
                r_step <= r_step + 1'b1;
            end
            S_NEXT: begin
                if (!is_last) begin
                    r_idx <= r_idx + 1'b1;
                end else if (t_req'(r_req) == REQ_REMOVE) begin
                    r_status <= ST_NOT_FOUND;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    if (t_req'(r_req) == REQ_RESOLVE) begin
                        r_out_data <= {3'b000, r_slot, r_hits, r_pz, r_py, r_px};
                    end else begin
                        r_out_data <= {3'b000, r_slot, 7'd0, 96'd0};
                    end
                    r_out_user <= r_status;
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // one request in flight at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_s_axis_tready)
        else $error("request accepted while another is in flight");

    // divider remainder stays below the root
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_root))
        else $error("divider remainder not below divisor");

    // a pending result is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !out_load)
        else $error("output register overwritten while stalled");

    // hit count only grows during a walk
    a_hits_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && $past(r_state) != S_IDLE) |-> (r_hits >= $past(r_hits)))
        else $error("hit count decreased");

endmodule

FILE: test/sphere_collision_resolver_test.sv
// ----------------------------------------------------------------------------
// sphere_collision_resolver_test: self-checking bench for the sphere resolver
// Drives add, remove, resolve and no-op requests, directed and in random bursts,
// predicts every result from a shadow slot table and exact integer push-out math,
// and checks each output transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sphere_collision_resolver_test;
    timeunit 1ns;
    timeprecision 1ps;
    import scr_pkg::*;

    localparam int NSLOT     = 64;
    localparam int IDLE_LIMIT = 200000;

    typedef struct {
        t_req             req;
        logic [15:0]      id;
        logic [31:0]      x, y, z;
        logic [30:0]      r;
    } t_req_item;

    typedef struct {
        logic [31:0] x, y, z;
        logic [6:0]  hits;
        logic [5:0]  slot;
        logic [1:0]  status;
    } t_answer;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic [143:0] s_data = '0;
    logic [1:0]   s_user = '0;
    logic         m_ready = 1'b0;
    wire          o_s_axis_tready;
    wire          o_m_axis_tvalid;
    wire [111:0]  o_m_axis_tdata;
    wire [1:0]    o_m_axis_tuser;

    sphere_collision_resolver dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    t_req_item pending_reqs[$];
    t_answer   expected_answers[$];
    int        errors = 0;

    // shadow table used by the predictor
    bit                tbl_valid[NSLOT];
    logic [15:0]       tbl_id[NSLOT];
    longint            tbl_cx[NSLOT], tbl_cy[NSLOT], tbl_cz[NSLOT];
    longint unsigned   tbl_rad[NSLOT];

    // stimulus-side view of what is stored, to aim removes and resolves
    t_req_item gen_spheres[$];

    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint push_comp(longint d, longint unsigned s, longint unsigned len);
        longint unsigned q;
        q = (abs64(d) * s) / len;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_answer predict_answer(t_req_item it);
        t_answer         a;
        longint          p[3];
        longint          d[3];
        longint unsigned s, lim, acc, m, n, len;
        int              i, k, hits;
        bit              hit;
        a = '{default: '0};
        p[0] = longint'(signed'(it.x));
        p[1] = longint'(signed'(it.y));
        p[2] = longint'(signed'(it.z));
        case (it.req)
            REQ_ADD: begin
                i = 0;
                while (i < NSLOT && tbl_valid[i]) i++;
                if (i == NSLOT) begin
                    a.status = ST_FULL;
                end else begin
                    tbl_valid[i] = 1'b1;
                    tbl_id[i] = it.id;
                    tbl_cx[i] = p[0];
                    tbl_cy[i] = p[1];
                    tbl_cz[i] = p[2];
                    tbl_rad[i] = it.r;
                    a.slot = i[5:0];
                    a.status = ST_OK;
                end
            end
            REQ_REMOVE: begin
                i = 0;
                while (i < NSLOT && !(tbl_valid[i] && tbl_id[i] == it.id)) i++;
                if (i == NSLOT) begin
                    a.status = ST_NOT_FOUND;
                end else begin
                    tbl_valid[i] = 1'b0;
                    a.slot = i[5:0];
                    a.status = ST_OK;
                end
            end
            REQ_RESOLVE: begin
                hits = 0;
                for (i = 0; i < NSLOT; i++) begin
                    if (tbl_valid[i]) begin
                        s = longint'(it.r) + tbl_rad[i];
                        d[0] = p[0] - tbl_cx[i];
                        d[1] = p[1] - tbl_cy[i];
                        d[2] = p[2] - tbl_cz[i];
                        hit = (s != 0);
                        lim = s * s;
                        acc = 0;
                        for (k = 0; k < 3 && hit; k++) begin
                            m = abs64(d[k]);
                            if (m >= s) begin
                                hit = 1'b0;
                            end else begin
                                n = acc + m * m;
                                if (n < acc || n >= lim) hit = 1'b0;
                                else acc = n;
                            end
                        end
                        if (hit) begin
                            if (acc == 0) begin
                                // coincident centers: push along +x
                                p[0] = clamp32(tbl_cx[i] + longint'(s));
                                p[1] = clamp32(tbl_cy[i]);
                                p[2] = clamp32(tbl_cz[i]);
                            end else begin
                                len = int_sqrt(acc);
                                p[0] = clamp32(tbl_cx[i] + push_comp(d[0], s, len));
                                p[1] = clamp32(tbl_cy[i] + push_comp(d[1], s, len));
                                p[2] = clamp32(tbl_cz[i] + push_comp(d[2], s, len));
                            end
                            if (hits < 127) hits++;
                        end
                    end
                end
                a.x = p[0][31:0];
                a.y = p[1][31:0];
                a.z = p[2][31:0];
                a.hits = hits[6:0];
            end
            default: ;
        endcase
        return a;
    endfunction

    // ---------------- driver ----------------
    int        burst_left = 0;
    int        gap_left = 0;
    t_req_item cur_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || o_s_axis_tready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                cur_req = pending_reqs.pop_front();
                s_data <= {1'b0, cur_req.r, cur_req.z, cur_req.y, cur_req.x, cur_req.id};
                s_user <= cur_req.req;
                s_valid <= 1'b1;
                expected_answers.insert(expected_answers.size(), predict_answer(cur_req));
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------- receiver stall pattern ----------------
    int ready_mode = 0;
    int ready_left = 0;

    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode <= $urandom_range(0, 2);
            ready_left <= $urandom_range(1, 60);
            m_ready <= 1'b1;
        end else begin
            ready_left <= ready_left - 1;
            case (ready_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= $urandom_range(0, 1);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ---------------- monitor ----------------
    t_answer want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: unexpected result tdata=%h tuser=%h", $time,
                         o_m_axis_tdata, o_m_axis_tuser);
                errors++;
            end else begin
                want = expected_answers.pop_front();
                if (o_m_axis_tdata[31:0] !== want.x) begin
                    $display("%0t: new_x expected %h actual %h", $time, want.x,
                             o_m_axis_tdata[31:0]);
                    errors++;
                end
                if (o_m_axis_tdata[63:32] !== want.y) begin
                    $display("%0t: new_y expected %h actual %h", $time, want.y,
                             o_m_axis_tdata[63:32]);
                    errors++;
                end
                if (o_m_axis_tdata[95:64] !== want.z) begin
                    $display("%0t: new_z expected %h actual %h", $time, want.z,
                             o_m_axis_tdata[95:64]);
                    errors++;
                end
                if (o_m_axis_tdata[102:96] !== want.hits) begin
                    $display("%0t: hits expected %0d actual %0d", $time, want.hits,
                             o_m_axis_tdata[102:96]);
                    errors++;
                end
                if (o_m_axis_tdata[108:103] !== want.slot) begin
                    $display("%0t: slot expected %0d actual %0d", $time, want.slot,
                             o_m_axis_tdata[108:103]);
                    errors++;
                end
                if (o_m_axis_tuser !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             o_m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------
    function automatic int near(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic t_req_item mk(t_req q, logic [15:0] id, logic [31:0] x,
                                     logic [31:0] y, logic [31:0] z, logic [30:0] r);
        t_req_item it;
        it.req = q;
        it.id = id;
        it.x = x;
        it.y = y;
        it.z = z;
        it.r = r;
        return it;
    endfunction

    task automatic queue_req(t_req_item it);
        int j;
        if (it.req == REQ_ADD && gen_spheres.size() < NSLOT)
            gen_spheres.insert(gen_spheres.size(), it);
        if (it.req == REQ_REMOVE) begin
            for (j = 0; j < gen_spheres.size(); j++) begin
                if (gen_spheres[j].id == it.id) begin
                    gen_spheres.delete(j);
                    break;
                end
            end
        end
        pending_reqs.insert(pending_reqs.size(), it);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_valid || expected_answers.size() > 0)
            @(posedge i_clk);
    endtask

    t_req_item tmp;
    int        n, phase, pick, w_add, w_rem, j;

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        queue_req(mk(REQ_RESOLVE, 16'h0, 32'h0, 32'h0, 32'h0, 31'h10000));
        queue_req(mk(REQ_REMOVE, 16'h1234, 32'h0, 32'h0, 32'h0, 31'h0));
        queue_req(mk(REQ_ADD, 16'h0, 32'h0, 32'h0, 32'h0, 31'h10000));
        queue_req(mk(REQ_ADD, 16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                     31'h7FFFFFFF));
        queue_req(mk(REQ_ADD, 16'h5, 32'h80000000, 32'h80000000, 32'h80000000, 31'h0));
        queue_req(mk(REQ_ADD, 16'h7, 32'h100000, 32'h0, 32'h0, 31'h0));
        // coincident centers
        queue_req(mk(REQ_RESOLVE, 16'h0, 32'h0, 32'h0, 32'h0, 31'h10000));
        // zero radius sum against the zero-radius spheres
        queue_req(mk(REQ_RESOLVE, 16'h0, 32'h100000, 32'h0, 32'h0, 31'h0));
        queue_req(mk(REQ_RESOLVE, 16'h0, 32'h80000000, 32'h80000000, 32'h80000000, 31'h0));
        // saturation near the positive corner
        queue_req(mk(REQ_RESOLVE, 16'h0, 32'h7FFF0000, 32'h7FFFF000, 32'h7FFFFFFF,
                     31'h7FFFFFFF));
        queue_req(mk(REQ_RESOLVE, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                     31'h7FFFFFFF));
        queue_req(mk(REQ_RESOLVE, 16'h0, 32'h8000, 32'hFFFF8000, 32'h4000, 31'h8000));
        queue_req(mk(REQ_RESOLVE, 16'h0, 32'h40000000, 32'hC0000000, 32'h0, 31'h100));
        queue_req(mk(REQ_ADD, 16'h0, 32'h30000, 32'h0, 32'h0, 31'h10000));
        queue_req(mk(REQ_RESOLVE, 16'h0, 32'h18000, 32'h100, 32'h0, 31'h10000));
        queue_req(mk(REQ_REMOVE, 16'h0, 32'h0, 32'h0, 32'h0, 31'h0));
        queue_req(mk(REQ_REMOVE, 16'hFFFF, 32'h0, 32'h0, 32'h0, 31'h0));
        queue_req(mk(REQ_NONE, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                     31'h7FFFFFFF));
        queue_req(mk(REQ_RESOLVE, 16'h0, 32'h18000, 32'h0, 32'h0, 31'h10000));
        queue_req(mk(REQ_REMOVE, 16'h5, 32'h0, 32'h0, 32'h0, 31'h0));
        queue_req(mk(REQ_REMOVE, 16'h7, 32'h0, 32'h0, 32'h0, 31'h0));
        queue_req(mk(REQ_REMOVE, 16'h0, 32'h0, 32'h0, 32'h0, 31'h0));

        // hold off until everything has come back
        drain();

        for (n = 0; n < 550; n++) begin
            phase = n / 110;
            w_add = (phase == 0 || phase == 3) ? 60 : (phase == 2 ? 10 : 25);
            w_rem = (phase == 2) ? 45 : 15;
            pick = $urandom_range(0, 99);
            tmp.id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
            tmp.x = near(1 << 20);
            tmp.y = near(1 << 20);
            tmp.z = near(1 << 20);
            tmp.r = 31'($urandom_range(0, 1 << 19));
            if (pick < 3) begin
                tmp.req = REQ_NONE;
            end else if (pick < w_add) begin
                tmp.req = REQ_ADD;
            end else if (pick < w_add + w_rem) begin
                tmp.req = REQ_REMOVE;
                if (gen_spheres.size() > 0 && $urandom_range(0, 4) != 0)
                    tmp.id = gen_spheres[$urandom_range(0, gen_spheres.size() - 1)].id;
            end else begin
                tmp.req = REQ_RESOLVE;
                if (gen_spheres.size() > 0 && $urandom_range(0, 3) != 0) begin
                    j = $urandom_range(0, gen_spheres.size() - 1);
                    tmp.x = gen_spheres[j].x + near(1 << 17);
                    tmp.y = gen_spheres[j].y + near(1 << 17);
                    tmp.z = gen_spheres[j].z + near(1 << 17);
                    if ($urandom_range(0, 9) == 0) begin
                        tmp.x = gen_spheres[j].x;
                        tmp.y = gen_spheres[j].y;
                        tmp.z = gen_spheres[j].z;
                    end
                end
            end
            // occasional full-range noise on every field
            if ($urandom_range(0, 19) == 0) begin
                tmp.x = $urandom;
                tmp.y = $urandom;
                tmp.z = $urandom;
                tmp.r = 31'($urandom);
                tmp.id = 16'($urandom);
            end
            queue_req(tmp);
        end

        drain();
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
